// ===== hdl/ebc_pkg.sv =====
// shared types, codes and opcode decode for the eight-bit cpu subset core
package ebc_pkg;

   localparam int MEM_BYTES_DEF = 65536;

   localparam logic [7:0] FLAGS_RESET = 8'h24;
   localparam logic [7:0] SP_RESET    = 8'hFF;
   localparam logic [7:0] FILL_BYTE   = 8'hFF;
   localparam logic [7:0] STACK_PAGE  = 8'h01;

   // opcodes
   localparam logic [7:0] OP_ORA_INDX = 8'h01;
   localparam logic [7:0] OP_ASL_ZP   = 8'h06;
   localparam logic [7:0] OP_PHP      = 8'h08;
   localparam logic [7:0] OP_ASL_A    = 8'h0A;
   localparam logic [7:0] OP_ASL_ABS  = 8'h0E;
   localparam logic [7:0] OP_BPL      = 8'h10;
   localparam logic [7:0] OP_ASL_ABSX = 8'h1E;
   localparam logic [7:0] OP_JSR      = 8'h20;
   localparam logic [7:0] OP_EOR_IMM  = 8'h49;
   localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
   localparam logic [7:0] OP_RTS      = 8'h60;
   localparam logic [7:0] OP_STA_ZP   = 8'h85;
   localparam logic [7:0] OP_STX_ZP   = 8'h86;
   localparam logic [7:0] OP_STA_ABS  = 8'h8D;
   localparam logic [7:0] OP_STX_ABS  = 8'h8E;
   localparam logic [7:0] OP_STA_INDY = 8'h91;
   localparam logic [7:0] OP_TXS      = 8'h9A;
   localparam logic [7:0] OP_STA_ABSX = 8'h9D;
   localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
   localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
   localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
   localparam logic [7:0] OP_LDX_ZP   = 8'hA6;
   localparam logic [7:0] OP_TAY      = 8'hA8;
   localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
   localparam logic [7:0] OP_LDY_ABS  = 8'hAC;
   localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
   localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
   localparam logic [7:0] OP_CPY_IMM  = 8'hC0;
   localparam logic [7:0] OP_INY      = 8'hC8;
   localparam logic [7:0] OP_DEX      = 8'hCA;
   localparam logic [7:0] OP_BNE      = 8'hD0;
   localparam logic [7:0] OP_CLD      = 8'hD8;
   localparam logic [7:0] OP_BEQ      = 8'hF0;

   typedef enum logic [1:0] {CMD_EXEC, CMD_WRITE, CMD_READ, CMD_NONE} cmd_type;

   typedef enum logic [2:0] {
      MODE_IMP, MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ABS, MODE_ABSX, MODE_INDX, MODE_INDY
   } mode_type;

   typedef enum logic [3:0] {
      KIND_ALU, KIND_READ, KIND_RMW, KIND_STA, KIND_STX, KIND_JMP, KIND_JSR, KIND_RTS, KIND_PHP
   } kind_type;

   typedef enum logic [4:0] {
      ALU_NONE, ALU_ORA, ALU_EOR, ALU_LDA, ALU_LDX, ALU_LDY, ALU_TAY, ALU_INY, ALU_DEX,
      ALU_TXS, ALU_CPY, ALU_CLD, ALU_ASLA, ALU_ASLM, ALU_BPL, ALU_BNE, ALU_BEQ
   } alu_type;

   typedef enum logic [2:0] {
      ASEL_PC, ASEL_EA, ASEL_PTR, ASEL_PTR1, ASEL_STACK, ASEL_POP, ASEL_REQ
   } addr_sel_type;

   typedef enum logic [2:0] {
      WSEL_A, WSEL_X, WSEL_ALU, WSEL_P, WSEL_RETHI, WSEL_RETLO, WSEL_REQ
   } wd_sel_type;

   typedef enum logic [2:0] {
      CAP_NONE, CAP_IR, CAP_OPL, CAP_OPH, CAP_EALO, CAP_EAHI, CAP_MDATA, CAP_RD
   } cap_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_OPL, S_OPH, S_EA, S_PTRL, S_PTRH, S_DRD,
      S_EXEC, S_WR, S_PUSH_P, S_PUSH_HI, S_PUSH_LO, S_POP_LO, S_POP_HI, S_JUMP,
      S_RTS_PC, S_MWR, S_MRD, S_RESP
   } state_type;

   typedef struct packed {
      logic     known;
      mode_type mode;
      kind_type kind;
      alu_type  alu;
   } decode_type;

   typedef struct packed {
      logic         mem_go;
      logic         mem_we;
      addr_sel_type addr_sel;
      wd_sel_type   wd_sel;
      logic         sp_dec;
      logic         sp_inc;
      cap_type      cap;
      logic         pc_inc;
      logic         add_y;
      logic         ea_go;
      mode_type     ea_mode;
      logic         alu_go;
      alu_type      alu;
      logic         pc_load_ea;
      logic         pc_load_ea1;
      logic         clr;
      logic         item_take;
      logic         rsp_load;
      logic         rsp_err;
   } dp_cmd_type;

   typedef struct packed {
      logic       mem_done;
      logic [7:0] opcode;
      logic       clr_last;
      logic       rsp_free;
   } dp_stat_type;

   function automatic decode_type mk_dec(input mode_type m, input kind_type k,
                                         input alu_type a);
      decode_type d;
      d.known = 1'b1;
      d.mode  = m;
      d.kind  = k;
      d.alu   = a;
      return d;
   endfunction

   function automatic decode_type decode_op(input logic [7:0] op);
      decode_type d;
      d = '{known: 1'b0, mode: MODE_IMP, kind: KIND_ALU, alu: ALU_NONE};
      case (op)
         OP_ORA_INDX: d = mk_dec(MODE_INDX, KIND_READ, ALU_ORA);
         OP_ASL_ZP:   d = mk_dec(MODE_ZP,   KIND_RMW,  ALU_ASLM);
         OP_PHP:      d = mk_dec(MODE_IMP,  KIND_PHP,  ALU_NONE);
         OP_ASL_A:    d = mk_dec(MODE_IMP,  KIND_ALU,  ALU_ASLA);
         OP_ASL_ABS:  d = mk_dec(MODE_ABS,  KIND_RMW,  ALU_ASLM);
         OP_BPL:      d = mk_dec(MODE_IMM,  KIND_ALU,  ALU_BPL);
         OP_ASL_ABSX: d = mk_dec(MODE_ABSX, KIND_RMW,  ALU_ASLM);
         OP_JSR:      d = mk_dec(MODE_ABS,  KIND_JSR,  ALU_NONE);
         OP_EOR_IMM:  d = mk_dec(MODE_IMM,  KIND_ALU,  ALU_EOR);
         OP_JMP_ABS:  d = mk_dec(MODE_ABS,  KIND_JMP,  ALU_NONE);
         OP_RTS:      d = mk_dec(MODE_IMP,  KIND_RTS,  ALU_NONE);
         OP_STA_ZP:   d = mk_dec(MODE_ZP,   KIND_STA,  ALU_NONE);
         OP_STX_ZP:   d = mk_dec(MODE_ZP,   KIND_STX,  ALU_NONE);
         OP_STA_ABS:  d = mk_dec(MODE_ABS,  KIND_STA,  ALU_NONE);
         OP_STX_ABS:  d = mk_dec(MODE_ABS,  KIND_STX,  ALU_NONE);
         OP_STA_INDY: d = mk_dec(MODE_INDY, KIND_STA,  ALU_NONE);
         OP_TXS:      d = mk_dec(MODE_IMP,  KIND_ALU,  ALU_TXS);
         OP_STA_ABSX: d = mk_dec(MODE_ABSX, KIND_STA,  ALU_NONE);
         OP_LDY_IMM:  d = mk_dec(MODE_IMM,  KIND_ALU,  ALU_LDY);
         OP_LDX_IMM:  d = mk_dec(MODE_IMM,  KIND_ALU,  ALU_LDX);
         OP_LDA_ZP:   d = mk_dec(MODE_ZP,   KIND_READ, ALU_LDA);
         OP_LDX_ZP:   d = mk_dec(MODE_ZP,   KIND_READ, ALU_LDX);
         OP_TAY:      d = mk_dec(MODE_IMP,  KIND_ALU,  ALU_TAY);
         OP_LDA_IMM:  d = mk_dec(MODE_IMM,  KIND_ALU,  ALU_LDA);
         OP_LDY_ABS:  d = mk_dec(MODE_ABS,  KIND_READ, ALU_LDY);
         OP_LDA_ZPX:  d = mk_dec(MODE_ZPX,  KIND_READ, ALU_LDA);
         OP_LDA_ABSX: d = mk_dec(MODE_ABSX, KIND_READ, ALU_LDA);
         OP_CPY_IMM:  d = mk_dec(MODE_IMM,  KIND_ALU,  ALU_CPY);
         OP_INY:      d = mk_dec(MODE_IMP,  KIND_ALU,  ALU_INY);
         OP_DEX:      d = mk_dec(MODE_IMP,  KIND_ALU,  ALU_DEX);
         OP_BNE:      d = mk_dec(MODE_IMM,  KIND_ALU,  ALU_BNE);
         OP_CLD:      d = mk_dec(MODE_IMP,  KIND_ALU,  ALU_CLD);
         OP_BEQ:      d = mk_dec(MODE_IMM,  KIND_ALU,  ALU_BEQ);
         default:     d.known = 1'b0;
      endcase
      return d;
   endfunction

endpackage

// ===== hdl/ebc_ctrl.sv =====
// controller state machine: sequences fetch, decode, memory accesses and execute
module ebc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  ebc_pkg::cmd_type         req_command,
   output logic                     req_tready,
   output ebc_pkg::dp_cmd_type      cmd,
   input  ebc_pkg::dp_stat_type     st
);
   import ebc_pkg::*;

   state_type  state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       err_ff, err_in;
   decode_type dec_ff, dec_in;
   decode_type dec_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pend_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

   always_comb begin
      state_in   = state_ff;
      err_in     = err_ff;
      dec_in     = dec_ff;
      dec_now    = decode_op(st.opcode);
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.item_take = 1'b1;
               err_in        = 1'b0;
               case (req_command)
                  CMD_EXEC:  state_in = S_FETCH;
                  CMD_WRITE: state_in = S_MWR;
                  CMD_READ:  state_in = S_MRD;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_FETCH: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_PC;
            if (st.mem_done) begin
               cmd.cap    = CAP_IR;
               cmd.pc_inc = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            dec_in = dec_now;
            if (!dec_now.known) begin
               err_in   = 1'b1;
               state_in = S_RESP;
            end else if (dec_now.mode == MODE_IMP) begin
               case (dec_now.kind)
                  KIND_PHP: state_in = S_PUSH_P;
                  KIND_RTS: state_in = S_POP_LO;
                  default:  state_in = S_EXEC;
               endcase
            end else begin
               state_in = S_OPL;
            end
         end
         S_OPL: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_PC;
            if (st.mem_done) begin
               cmd.cap    = CAP_OPL;
               cmd.pc_inc = 1'b1;
               case (dec_ff.mode)
                  MODE_IMM:  state_in = S_EXEC;
                  MODE_ABS:  state_in = S_OPH;
                  MODE_ABSX: state_in = S_OPH;
                  default:   state_in = S_EA;
               endcase
            end
         end
         S_OPH: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_PC;
            if (st.mem_done) begin
               cmd.cap    = CAP_OPH;
               cmd.pc_inc = 1'b1;
               state_in   = S_EA;
            end
         end
         S_EA: begin
            cmd.ea_go   = 1'b1;
            cmd.ea_mode = dec_ff.mode;
            if (dec_ff.mode == MODE_INDX || dec_ff.mode == MODE_INDY) begin
               state_in = S_PTRL;
            end else begin
               case (dec_ff.kind)
                  KIND_JMP: state_in = S_JUMP;
                  KIND_JSR: state_in = S_PUSH_HI;
                  KIND_STA: state_in = S_WR;
                  KIND_STX: state_in = S_WR;
                  default:  state_in = S_DRD;
               endcase
            end
         end
         S_PTRL: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_PTR;
            if (st.mem_done) begin
               cmd.cap  = CAP_EALO;
               state_in = S_PTRH;
            end
         end
         S_PTRH: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_PTR1;
            if (st.mem_done) begin
               cmd.cap   = CAP_EAHI;
               cmd.add_y = (dec_ff.mode == MODE_INDY);
               state_in  = (dec_ff.kind == KIND_STA) ? S_WR : S_DRD;
            end
         end
         S_DRD: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_EA;
            if (st.mem_done) begin
               cmd.cap  = CAP_MDATA;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.alu_go = 1'b1;
            cmd.alu    = dec_ff.alu;
            state_in   = (dec_ff.kind == KIND_RMW) ? S_WR : S_RESP;
         end
         S_WR: begin
            cmd.mem_go   = !pend_ff;
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ASEL_EA;
            case (dec_ff.kind)
               KIND_STA: cmd.wd_sel = WSEL_A;
               KIND_STX: cmd.wd_sel = WSEL_X;
               default:  cmd.wd_sel = WSEL_ALU;
            endcase
            if (st.mem_done) state_in = S_RESP;
         end
         S_PUSH_P: begin
            cmd.mem_go   = !pend_ff;
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ASEL_STACK;
            cmd.wd_sel   = WSEL_P;
            cmd.sp_dec   = !pend_ff;
            if (st.mem_done) state_in = S_RESP;
         end
         S_PUSH_HI: begin
            cmd.mem_go   = !pend_ff;
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ASEL_STACK;
            cmd.wd_sel   = WSEL_RETHI;
            cmd.sp_dec   = !pend_ff;
            if (st.mem_done) state_in = S_PUSH_LO;
         end
         S_PUSH_LO: begin
            cmd.mem_go   = !pend_ff;
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ASEL_STACK;
            cmd.wd_sel   = WSEL_RETLO;
            cmd.sp_dec   = !pend_ff;
            if (st.mem_done) state_in = S_JUMP;
         end
         S_JUMP: begin
            cmd.pc_load_ea = 1'b1;
            state_in       = S_RESP;
         end
         S_POP_LO: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_POP;
            cmd.sp_inc   = !pend_ff;
            if (st.mem_done) begin
               cmd.cap  = CAP_EALO;
               state_in = S_POP_HI;
            end
         end
         S_POP_HI: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_POP;
            cmd.sp_inc   = !pend_ff;
            if (st.mem_done) begin
               cmd.cap  = CAP_EAHI;
               state_in = S_RTS_PC;
            end
         end
         S_RTS_PC: begin
            cmd.pc_load_ea1 = 1'b1;
            state_in        = S_RESP;
         end
         S_MWR: begin
            cmd.mem_go   = !pend_ff;
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = ASEL_REQ;
            cmd.wd_sel   = WSEL_REQ;
            if (st.mem_done) state_in = S_RESP;
         end
         S_MRD: begin
            cmd.mem_go   = !pend_ff;
            cmd.addr_sel = ASEL_REQ;
            if (st.mem_done) begin
               cmd.cap  = CAP_RD;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (st.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_err  = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // one access in flight at a time
      if (st.mem_done)      pend_in = 1'b0;
      else if (cmd.mem_go)  pend_in = 1'b1;
      else                  pend_in = pend_ff;
   end

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> st.rsp_free)
      else $error("response loaded while output register still full");

   a_no_reissue: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !cmd.mem_go)
      else $error("memory access issued while one is pending");

   a_done_pending: assert property (@(posedge clock) disable iff (reset)
      st.mem_done |-> pend_ff)
      else $error("memory completion without a pending access");

endmodule

// ===== hdl/ebc_datapath.sv =====
// datapath: register file, alu, byte memory with address reduction, output register
module ebc_datapath #(
   parameter int MEM_BYTES = ebc_pkg::MEM_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ebc_pkg::dp_cmd_type   cmd,
   output ebc_pkg::dp_stat_type  st,
   input  logic [15:0]           req_address,
   input  logic [7:0]            req_data,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [63:0]           rsp_tdata,
   output logic                  rsp_tuser
);
   import ebc_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);
   localparam int RW = 34 - AW;
   localparam int QW = RW - 16;
   // ceil(2^32 / MEM_BYTES): exact floor quotient for any 16-bit address
   localparam logic [RW-1:0] RECIP =
      RW'(((64'd1 << 32) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES));
   localparam logic [16:0] MEM_M = 17'(MEM_BYTES);

   logic [7:0] mem [MEM_BYTES];

   // architectural and working registers
   logic [15:0] pc_ff, pc_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic [7:0]  ir_ff, ir_in, op8_ff, op8_in, oph_ff, oph_in, ptr_ff, ptr_in;
   logic [7:0]  mdata_ff, mdata_in, aluw_ff, aluw_in, rd_ff, rd_in;
   logic [15:0] ea_ff, ea_in;
   logic [15:0] raddr_ff, raddr_in;
   logic [7:0]  rdat_ff, rdat_in;

   // memory pipeline
   logic              mv0_ff, mv1_ff, mv2_ff, done_ff;
   logic              mw0_ff, mw1_ff, mw2_ff;
   logic [15:0]       ma0_ff, ma1_ff;
   logic [7:0]        md0_ff, md1_ff, md2_ff;
   logic [QW-1:0]     q_ff;
   logic [AW-1:0]     phys_ff;
   logic [7:0]        rdata_ff;
   logic [AW-1:0]     clr_ff;
   logic [15:0]       maddr;
   logic [7:0]        mwd;
   logic [RW+15:0]    prod;
   logic [16:0]       reduced;
   logic [15:0]       ret_addr;

   // output register
   logic        rsp_valid_ff;
   logic        rsp_err_ff;
   logic [63:0] rsp_data_ff;

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] r);
      return {r[7], p[6:2], (r == 8'h00), p[0]};
   endfunction

   assign ret_addr = pc_ff - 16'd1;

   always_comb begin
      case (cmd.addr_sel)
         ASEL_PC:    maddr = pc_ff;
         ASEL_EA:    maddr = ea_ff;
         ASEL_PTR:   maddr = {8'h00, ptr_ff};
         ASEL_PTR1:  maddr = {8'h00, ptr_ff + 8'd1};
         ASEL_STACK: maddr = {STACK_PAGE, sp_ff};
         ASEL_POP:   maddr = {STACK_PAGE, sp_ff + 8'd1};
         ASEL_REQ:   maddr = raddr_ff;
         default:    maddr = pc_ff;
      endcase
      case (cmd.wd_sel)
         WSEL_A:     mwd = a_ff;
         WSEL_X:     mwd = x_ff;
         WSEL_ALU:   mwd = aluw_ff;
         WSEL_P:     mwd = p_ff;
         WSEL_RETHI: mwd = ret_addr[15:8];
         WSEL_RETLO: mwd = ret_addr[7:0];
         WSEL_REQ:   mwd = rdat_ff;
         default:    mwd = a_ff;
      endcase
   end

   assign prod    = (RW+16)'(ma0_ff) * (RW+16)'(RECIP);
   assign reduced = 17'(ma1_ff) - 17'(q_ff) * MEM_M;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv0_ff  <= 1'b0;
         mv1_ff  <= 1'b0;
         mv2_ff  <= 1'b0;
         done_ff <= 1'b0;
         clr_ff  <= '0;
      end else begin
         mv0_ff  <= cmd.mem_go;
         mv1_ff  <= mv0_ff;
         mv2_ff  <= mv1_ff;
         done_ff <= mv2_ff;
         if (cmd.clr) clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      ma0_ff  <= maddr;
      mw0_ff  <= cmd.mem_we;
      md0_ff  <= mwd;
      ma1_ff  <= ma0_ff;
      mw1_ff  <= mw0_ff;
      md1_ff  <= md0_ff;
      q_ff    <= prod[RW+15:32];
      phys_ff <= reduced[AW-1:0];
      mw2_ff  <= mw1_ff;
      md2_ff  <= md1_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mem[clr_ff] <= FILL_BYTE;
      end else if (mv2_ff && mw2_ff) begin
         mem[phys_ff] <= md2_ff;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[phys_ff];
   end

   always_comb begin
      pc_in    = pc_ff;
      a_in     = a_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      sp_in    = sp_ff;
      p_in     = p_ff;
      ir_in    = ir_ff;
      op8_in   = op8_ff;
      oph_in   = oph_ff;
      ptr_in   = ptr_ff;
      mdata_in = mdata_ff;
      aluw_in  = aluw_ff;
      rd_in    = rd_ff;
      ea_in    = ea_ff;
      raddr_in = raddr_ff;
      rdat_in  = rdat_ff;

      if (cmd.item_take) begin
         rd_in    = 8'h00;
         raddr_in = req_address;
         rdat_in  = req_data;
      end

      case (cmd.cap)
         CAP_IR:    ir_in = rdata_ff;
         CAP_OPL: begin
            op8_in   = rdata_ff;
            mdata_in = rdata_ff;
         end
         CAP_OPH:   oph_in = rdata_ff;
         CAP_EALO:  ea_in = {ea_ff[15:8], rdata_ff};
         CAP_EAHI:  ea_in = {rdata_ff, ea_ff[7:0]} + {8'h00, (cmd.add_y ? y_ff : 8'h00)};
         CAP_MDATA: mdata_in = rdata_ff;
         CAP_RD:    rd_in = rdata_ff;
         default:   ;
      endcase

      if (cmd.pc_inc) pc_in = pc_ff + 16'd1;
      if (cmd.sp_dec) sp_in = sp_ff - 8'd1;
      if (cmd.sp_inc) sp_in = sp_ff + 8'd1;

      if (cmd.ea_go) begin
         case (cmd.ea_mode)
            MODE_ZP:   ea_in  = {8'h00, op8_ff};
            MODE_ZPX:  ea_in  = {8'h00, op8_ff + x_ff};
            MODE_ABS:  ea_in  = {oph_ff, op8_ff};
            MODE_ABSX: ea_in  = {oph_ff, op8_ff} + {8'h00, x_ff};
            MODE_INDX: ptr_in = op8_ff + x_ff;
            MODE_INDY: ptr_in = op8_ff;
            default:   ;
         endcase
      end

      if (cmd.alu_go) begin
         case (cmd.alu)
            ALU_ORA: begin
               a_in = a_ff | mdata_ff;
               p_in = set_nz(p_ff, a_in);
            end
            ALU_EOR: begin
               a_in = a_ff ^ mdata_ff;
               p_in = set_nz(p_ff, a_in);
            end
            ALU_LDA: begin
               a_in = mdata_ff;
               p_in = set_nz(p_ff, a_in);
            end
            ALU_LDX: begin
               x_in = mdata_ff;
               p_in = set_nz(p_ff, x_in);
            end
            ALU_LDY: begin
               y_in = mdata_ff;
               p_in = set_nz(p_ff, y_in);
            end
            ALU_TAY: begin
               y_in = a_ff;
               p_in = set_nz(p_ff, y_in);
            end
            ALU_INY: begin
               y_in = y_ff + 8'd1;
               p_in = set_nz(p_ff, y_in);
            end
            ALU_DEX: begin
               x_in = x_ff - 8'd1;
               p_in = set_nz(p_ff, x_in);
            end
            ALU_TXS: sp_in = x_ff;
            ALU_CPY: begin
               p_in    = set_nz(p_ff, y_ff - mdata_ff);
               p_in[0] = (y_ff >= mdata_ff);
            end
            ALU_CLD: p_in[3] = 1'b0;
            ALU_ASLA: begin
               a_in    = {a_ff[6:0], 1'b0};
               p_in    = set_nz(p_ff, a_in);
               p_in[0] = a_ff[7];
            end
            ALU_ASLM: begin
               aluw_in = {mdata_ff[6:0], 1'b0};
               p_in    = set_nz(p_ff, aluw_in);
               p_in[0] = mdata_ff[7];
            end
            ALU_BPL: if (!p_ff[7]) pc_in = pc_ff + {{8{mdata_ff[7]}}, mdata_ff};
            ALU_BNE: if (!p_ff[1]) pc_in = pc_ff + {{8{mdata_ff[7]}}, mdata_ff};
            ALU_BEQ: if (p_ff[1])  pc_in = pc_ff + {{8{mdata_ff[7]}}, mdata_ff};
            default: ;
         endcase
      end

      if (cmd.pc_load_ea)  pc_in = ea_ff;
      if (cmd.pc_load_ea1) pc_in = ea_ff + 16'd1;
      // start address write acts as a reset vector
      if (csr_wr_en)       pc_in = csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 16'h0000;
         a_ff  <= 8'h00;
         x_ff  <= 8'h00;
         y_ff  <= 8'h00;
         sp_ff <= SP_RESET;
         p_ff  <= FLAGS_RESET;
      end else begin
         pc_ff <= pc_in;
         a_ff  <= a_in;
         x_ff  <= x_in;
         y_ff  <= y_in;
         sp_ff <= sp_in;
         p_ff  <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      ir_ff    <= ir_in;
      op8_ff   <= op8_in;
      oph_ff   <= oph_in;
      ptr_ff   <= ptr_in;
      mdata_ff <= mdata_in;
      aluw_ff  <= aluw_in;
      rd_ff    <= rd_in;
      ea_ff    <= ea_in;
      raddr_ff <= raddr_in;
      rdat_ff  <= rdat_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_err_ff  <= cmd.rsp_err;
         rsp_data_ff <= {p_ff, sp_ff, y_ff, x_ff, a_ff, pc_ff, rd_ff};
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign rsp_tuser   = rsp_err_ff;

   assign st.mem_done = done_ff;
   assign st.opcode   = ir_ff;
   assign st.clr_last = (clr_ff == AW'(MEM_BYTES - 1));
   assign st.rsp_free = !rsp_valid_ff || rsp_tready;

   a_clr_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.clr |-> !(mv2_ff && mw2_ff))
      else $error("clearing pass overlaps a memory write");

   a_single_access: assert property (@(posedge clock) disable iff (reset)
      mv0_ff |-> (!mv1_ff && !mv2_ff && !done_ff))
      else $error("two memory accesses overlap in the pipeline");

endmodule

// ===== hdl/eight_bit_cpu_subset_core.sv =====
// top level of the eight-bit cpu subset core
//
// channel   direction  handshake              payload
// req_      in         req_tvalid/req_tready  tdata: address, data; tuser: command
// rsp_      out        rsp_tvalid/rsp_tready  tdata: read_data .. flags; tuser: status
// csr_      in         csr_wr_en              csr_wr_data: boot address, also loads pc
//
// every memory access passes through address register, reciprocal multiply for the
// modulo MEM_BYTES reduction, subtract, registered memory read or write, capture.
// an instruction, an unknown opcode, a memory write or read command and command 3 each
// end with a load of the output register. after reset a clearing pass fills the memory
// with 0xff; no transaction is accepted meanwhile, start address writes are.
// a finished result waits in the output register while the next item is accepted.
module eight_bit_cpu_subset_core #(
   parameter int MEM_BYTES = ebc_pkg::MEM_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] address, [23:16] data
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [23:8] program_counter, [31:24] accumulator, [39:32] index_x,
   // [47:40] index_y, [55:48] stack_pointer, [63:56] flags
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] status
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import ebc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type st;

   ebc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (cmd_type'(req_tuser)),
      .req_tready  (req_tready),
      .cmd         (cmd),
      .st          (st)
   );

   ebc_datapath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .req_address (req_tdata[15:0]),
      .req_data    (req_tdata[23:16]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
